@@ rtl/core/mlht_pkg.sv @@
// package for the max line hull table: payload structs, widths, status codes
// no dependencies
`timescale 1ns / 1ps
package mlht_pkg;
   localparam int MaxLinesDefault = 64;
   localparam int CoefBitsDefault = 32;
   localparam int FieldBits = 32;
   localparam int ValueBits = 63;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                        opcode;
      logic signed [FieldBits-1:0] slope;
      logic signed [FieldBits-1:0] intercept;
      logic signed [FieldBits-1:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [ValueBits-1:0] max_value;
      logic [1:0]                  status;
   } rsp_type;
endpackage

@@ rtl/core/mlht_ram.sv @@
// generic simple dual port ram (separate write and read addresses) with registered read
// no dependencies
`timescale 1ns / 1ps
module mlht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/mlht_div.sv @@
// serial signed floor divider, one quotient bit per cycle
// depends on nothing beyond its parameters
`timescale 1ns / 1ps
module mlht_div #(
   parameter int Bits = 34
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic signed [Bits-1:0] num,
   input  logic signed [Bits-1:0] den,
   output logic                   done,
   output logic signed [Bits-1:0] quot
);
   localparam int CntBits = $clog2(Bits + 1);

   logic [Bits-1:0]    rem_ff, rem_in, dvs_ff, quo_ff, quo_in;
   logic [CntBits-1:0] cnt_ff;
   logic               busy_ff, neg_ff;
   logic [Bits:0]      trial;
   logic [Bits-1:0]    qmag;

   // restoring step on magnitudes
   always_comb begin
      trial  = {rem_ff, quo_ff[Bits-1]} - {1'b0, dvs_ff};
      quo_in = {quo_ff[Bits-2:0], ~trial[Bits]};
      rem_in = trial[Bits] ? {rem_ff[Bits-2:0], quo_ff[Bits-1]} : trial[Bits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntBits'(Bits);
            neg_ff  <= num[Bits-1] ^ den[Bits-1];
            rem_ff  <= '0;
            quo_ff  <= num[Bits-1] ? -num : num;
            dvs_ff  <= den[Bits-1] ? -den : den;
         end else if (busy_ff) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   // floor correction when signs differ and remainder nonzero
   assign qmag = quo_ff;
   assign quot = neg_ff ? ((rem_ff != '0) ? -qmag - 1'b1 : -qmag) : qmag;
endmodule

@@ rtl/core/max_line_hull_table.sv @@
// max line hull table: upper envelope of lines, add and max query
// an empty query or an add into a full table goes straight to the response; a query reads
// lines until a breakpoint reaches x or the last line; an add searches for its slot, shifts
// entries up, refreshes breakpoints (through the serial divider unless the slopes tie) and
// pulls entries down for each pruned line. busy drops in the strobe cycle
// reset: synchronous, empties the table (line count cleared); ram contents left as is
`timescale 1ns / 1ps
module max_line_hull_table
   import mlht_pkg::*;
#(
   parameter int MAX_LINES = MaxLinesDefault,
   parameter int COEF_BITS = CoefBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(MAX_LINES);
   localparam int CW = $clog2(MAX_LINES + 1);
   localparam int BW = COEF_BITS + 3;
   localparam int DW = COEF_BITS + 2;
   localparam int EW = 2 * COEF_BITS + BW;
   localparam int PW = 2 * COEF_BITS + 1;
   localparam logic signed [BW-1:0] Sent = BW'((64'(1) << (COEF_BITS + 2)) - 1);
   localparam logic signed [PW-1:0] VMax = PW'((64'sd1 <<< (ValueBits - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] VMin = -VMax - PW'(1);

   typedef struct packed {
      logic signed [COEF_BITS-1:0] s;
      logic signed [COEF_BITS-1:0] b;
      logic signed [BW-1:0]        p;
   } ent_type;

   typedef enum logic [4:0] {
      IDLE, QRD, QCHK, QMUL, QOUT,
      FRD, FCHK, SHRD, SHWR, INS,
      BPSET, BPRD, BPDIV, BPWAIT, BPWR,
      DRRD, DRWR, CHK_RD, CHK, BKRD, BKCHK, RESP
   } state_type;

   // pruning stage: forward, previous line, previous line after a drop, backward
   typedef enum logic [1:0] {
      PH_FWD, PH_PREV, PH_PREV_DROP, PH_BACK
   } phase_type;

   state_type            state_ff;
   phase_type            phase_ff;
   logic [CW-1:0]        count_ff;
   logic [AW-1:0]        idx_ff, m_ff, l_ff;
   logic [CW-1:0]        k_ff, dend_ff;
   ent_type              a_ff, b_ff, new_ff;
   logic signed [COEF_BITS-1:0] x_ff;
   logic signed [PW-1:0] prod_ff;
   logic [1:0]           status_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   ent_type              wr_data, rd_data;
   logic                 dgo, ddone;
   logic signed [DW-1:0] dnum, dden, dq;
   logic signed [ValueBits-1:0] sat;
   logic signed [PW-1:0] rsum;
   logic                 covered;

   mlht_ram #(.Width(EW), .Depth(MAX_LINES)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data(wr_data), .rd_addr, .rd_data(rd_data)
   );

   mlht_div #(.Bits(DW)) u_div (
      .clock, .reset, .go(dgo), .num(dnum), .den(dden), .done(ddone), .quot(dq)
   );

   assign dnum = DW'(b_ff.b) - DW'(a_ff.b);
   assign dden = DW'(a_ff.s) - DW'(b_ff.s);

   // line after l leaves the envelope
   assign covered = (CW'(l_ff) + 1'b1 < count_ff) && (a_ff.p >= b_ff.p);

   // saturate the query result to the output range
   assign rsum = prod_ff;
   always_comb begin
      if (PW > ValueBits && rsum > VMax)
         sat = {1'b0, {(ValueBits-1){1'b1}}};
      else if (PW > ValueBits && rsum < VMin)
         sat = {1'b1, {(ValueBits-1){1'b0}}};
      else
         sat = ValueBits'(rsum);
   end

   assign busy = (state_ff != IDLE);

   // sequencer: reads and writes the ram one entry at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
         wr_en     <= 1'b0;
         dgo       <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         wr_en     <= 1'b0;
         dgo       <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  status_ff <= STATUS_OK;
                  x_ff      <= COEF_BITS'(req_data.query_x);
                  new_ff.s  <= COEF_BITS'(req_data.slope);
                  new_ff.b  <= COEF_BITS'(req_data.intercept);
                  new_ff.p  <= Sent;
                  idx_ff    <= '0;
                  rd_addr   <= '0;
                  prod_ff   <= '0;
                  if (req_data.opcode == OP_QUERY) begin
                     if (count_ff == '0) begin
                        status_ff <= STATUS_EMPTY;
                        state_ff  <= RESP;
                     end else state_ff <= QRD;
                  end else if (count_ff == CW'(MAX_LINES)) begin
                     status_ff <= STATUS_FULL;
                     state_ff  <= RESP;
                  end else if (count_ff == '0) begin
                     state_ff <= INS;
                  end else state_ff <= FRD;
               end
            end
            // query scan
            QRD: state_ff <= QCHK;
            QCHK: begin
               if (CW'(idx_ff) + 1'b1 < count_ff &&
                   rd_data.p < BW'(x_ff)) begin
                  idx_ff   <= idx_ff + 1'b1;
                  rd_addr  <= idx_ff + 1'b1;
                  state_ff <= QRD;
               end else begin
                  a_ff     <= rd_data;
                  state_ff <= QMUL;
               end
            end
            QMUL: begin
               prod_ff  <= a_ff.s * x_ff;
               state_ff <= QOUT;
            end
            QOUT: begin
               prod_ff  <= prod_ff + PW'(a_ff.b);
               state_ff <= RESP;
            end
            // find insert position
            FRD: state_ff <= FCHK;
            FCHK: begin
               if (CW'(idx_ff) < count_ff && rd_data.s <= new_ff.s) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (CW'(idx_ff) + 1'b1 < count_ff) begin
                     rd_addr  <= idx_ff + 1'b1;
                     state_ff <= FRD;
                  end else state_ff <= INS;
               end else begin
                  k_ff    <= count_ff;
                  rd_addr <= AW'(count_ff - 1'b1);
                  state_ff <= (CW'(idx_ff) == count_ff) ? INS : SHRD;
               end
            end
            // shift entries up by one
            SHRD: state_ff <= SHWR;
            SHWR: begin
               wr_en   <= 1'b1;
               wr_addr <= AW'(k_ff);
               wr_data <= rd_data;
               k_ff    <= k_ff - 1'b1;
               rd_addr <= AW'(k_ff - 2'd2);
               state_ff <= (k_ff - 1'b1 == CW'(idx_ff)) ? INS : SHRD;
            end
            INS: begin
               wr_en    <= 1'b1;
               wr_addr  <= idx_ff;
               wr_data  <= new_ff;
               count_ff <= count_ff + 1'b1;
               m_ff     <= idx_ff;
               l_ff     <= idx_ff;
               phase_ff <= PH_FWD;
               state_ff <= BPSET;
            end
            // refresh breakpoint of entry l against l+1, then compare
            BPSET: begin
               rd_addr  <= l_ff;
               state_ff <= BPRD;
               k_ff     <= '0;
            end
            BPRD: begin
               if (k_ff == '0) begin
                  k_ff    <= CW'(1);
                  rd_addr <= l_ff + 1'b1;
               end else if (k_ff == CW'(1)) begin
                  a_ff    <= rd_data;
                  k_ff    <= CW'(2);
               end else begin
                  b_ff <= rd_data;
                  if (CW'(l_ff) + 1'b1 >= count_ff) begin
                     a_ff.p   <= Sent;
                     state_ff <= BPWR;
                  end else if (a_ff.s == rd_data.s) begin
                     a_ff.p   <= (a_ff.b > rd_data.b) ? Sent : -Sent;
                     state_ff <= BPWR;
                  end else begin
                     dgo      <= 1'b1;
                     state_ff <= BPDIV;
                  end
               end
            end
            BPDIV: state_ff <= BPWAIT;
            BPWAIT: if (ddone) begin
               a_ff.p   <= BW'(dq);
               state_ff <= BPWR;
            end
            BPWR: begin
               wr_en   <= 1'b1;
               wr_addr <= l_ff;
               wr_data <= a_ff;
               state_ff <= CHK_RD;
            end
            CHK_RD: state_ff <= CHK;
            // pruning decisions
            CHK: begin
               case (phase_ff)
                  PH_FWD: begin
                     if (covered) begin
                        k_ff     <= CW'(l_ff) + 1'b1;
                        rd_addr  <= AW'(CW'(l_ff) + 2'd2);
                        dend_ff  <= count_ff - 1'b1;
                        state_ff <= DRRD;
                     end else if (m_ff != '0) begin
                        phase_ff <= PH_PREV;
                        l_ff     <= m_ff - 1'b1;
                        state_ff <= BPSET;
                     end else state_ff <= RESP;
                  end
                  PH_PREV: begin
                     if (covered) begin
                        phase_ff <= PH_PREV_DROP;
                        k_ff     <= CW'(m_ff);
                        rd_addr  <= AW'(CW'(m_ff) + 1'b1);
                        dend_ff  <= count_ff - 1'b1;
                        state_ff <= DRRD;
                     end else if (l_ff == '0) begin
                        state_ff <= RESP;
                     end else begin
                        rd_addr  <= l_ff - 1'b1;
                        state_ff <= BKRD;
                     end
                  end
                  default: begin
                     if (l_ff == '0) begin
                        state_ff <= RESP;
                     end else begin
                        rd_addr  <= l_ff - 1'b1;
                        state_ff <= BKRD;
                     end
                  end
               endcase
            end
            // backward pruning: predecessor breakpoint against entry l
            BKRD: state_ff <= BKCHK;
            BKCHK: begin
               if (rd_data.p >= a_ff.p) begin
                  phase_ff <= PH_BACK;
                  k_ff     <= CW'(l_ff);
                  rd_addr  <= l_ff + 1'b1;
                  dend_ff  <= count_ff - 1'b1;
                  l_ff     <= l_ff - 1'b1;
                  state_ff <= DRRD;
               end else state_ff <= RESP;
            end
            // drop: pull entries down from k+1, each through a read and a write state
            DRRD: begin
               if (k_ff >= dend_ff) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= BPSET;
               end else state_ff <= DRWR;
            end
            DRWR: begin
               wr_en   <= 1'b1;
               wr_addr <= AW'(k_ff);
               wr_data <= rd_data;
               k_ff    <= k_ff + 1'b1;
               rd_addr <= AW'(k_ff + 2'd2);
               state_ff <= DRRD;
            end
            RESP: begin
               rsp_valid          <= 1'b1;
               rsp_data.status    <= status_ff;
               rsp_data.max_value <= sat;
               state_ff           <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // the table never holds more lines than it has entries
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_LINES))
      else $error("line count overflow");
   // a result is strobed only once the block is idle again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result while busy");
   // a full add is refused without changing the count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL) |-> count_ff == CW'(MAX_LINES))
      else $error("full status with free space");
endmodule

@@ tb/max_line_hull_table_tb.sv @@
// testbench for max_line_hull_table: directed and random line adds and max queries,
// checked against an in-bench envelope predictor. depends on mlht_pkg and the rtl top.
`timescale 1ns / 1ps
module max_line_hull_table_tb
   import mlht_pkg::*;
();

   localparam int     NumLines  = MaxLinesDefault;
   localparam longint Sentinel  = (64'sd1 <<< (CoefBitsDefault + 2)) - 1;
   localparam longint ValueMax  = (64'sd1 <<< 62) - 1;
   localparam longint ValueMin  = -ValueMax - 1;
   localparam int     IdleLimit = 50000;
   localparam int     DrainWait = 400;

   // envelope predictor plus queue of expected responses
   class hull_scoreboard;
      longint      slopes[NumLines];
      longint      icepts[NumLines];
      longint      bpoints[NumLines];
      int          count;
      rsp_type     pending_q[$];
      int          mismatches;

      function new();
         count = 0;
         mismatches = 0;
      endfunction

      function void remove_line(int i);
         if (i >= count) return;
         for (int k = i; k + 1 < count; k++) begin
            slopes[k]  = slopes[k+1];
            icepts[k]  = icepts[k+1];
            bpoints[k] = bpoints[k+1];
         end
         count--;
      endfunction

      // recompute breakpoint of line i; true when line i+1 falls off the envelope
      function bit update_bpoint(int i);
         longint num;
         longint den;
         longint q;
         if (i >= count) return 0;
         if (i + 1 >= count) begin
            bpoints[i] = Sentinel;
            return 0;
         end
         if (slopes[i] == slopes[i+1]) begin
            bpoints[i] = (icepts[i] > icepts[i+1]) ? Sentinel : -Sentinel;
         end else begin
            num = icepts[i+1] - icepts[i];
            den = slopes[i] - slopes[i+1];
            q = num / den;
            if ((num % den) != 0 && ((num < 0) != (den < 0))) q = q - 1;
            bpoints[i] = q;
         end
         return bpoints[i] >= bpoints[i+1];
      endfunction

      function void insert_line(longint a, longint b);
         int pos;
         int m;
         int l;
         pos = 0;
         while (pos < count && slopes[pos] <= a) pos++;
         for (int k = count; k > pos; k--) begin
            slopes[k]  = slopes[k-1];
            icepts[k]  = icepts[k-1];
            bpoints[k] = bpoints[k-1];
         end
         slopes[pos]  = a;
         icepts[pos]  = b;
         bpoints[pos] = 0;
         count++;
         m = pos;
         while (update_bpoint(m)) remove_line(m + 1);
         l = m;
         if (m > 0) begin
            l = m - 1;
            if (update_bpoint(l)) begin
               remove_line(m);
               void'(update_bpoint(l));
            end
         end
         while (l > 0 && bpoints[l-1] >= bpoints[l]) begin
            remove_line(l);
            void'(update_bpoint(l - 1));
            l--;
         end
      endfunction

      // accepted request transaction: update table, queue expected response
      function void note_request(req_type r);
         rsp_type e;
         longint  x;
         longint  v;
         int      i;
         e = '0;
         if (r.opcode == OP_ADD) begin
            if (count >= NumLines) e.status = STATUS_FULL;
            else insert_line(longint'(r.slope), longint'(r.intercept));
         end else if (count == 0) begin
            e.status = STATUS_EMPTY;
         end else begin
            x = longint'(r.query_x);
            i = 0;
            while (i + 1 < count && bpoints[i] < x) i++;
            v = slopes[i] * x + icepts[i];
            if (v > ValueMax) v = ValueMax;
            if (v < ValueMin) v = ValueMin;
            e.max_value = v[ValueBits-1:0];
            e.status = STATUS_OK;
         end
         pending_q.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: value %0d status %0d", a.max_value, a.status);
            return;
         end
         e = pending_q.pop_front();
         if (a.max_value !== e.max_value || a.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected value %0d status %0d, got value %0d status %0d",
                        e.max_value, e.status, a.max_value, a.status);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   hull_scoreboard sb;
   req_type        stim_q[$];
   int             burst_left;
   int             gap_left;
   int             idle_cycles;

   max_line_hull_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic req_type make_req(logic op, int s, int b, int x);
      req_type r;
      r.opcode    = op;
      r.slope     = s;
      r.intercept = b;
      r.query_x   = x;
      return r;
   endfunction

   function automatic int rand_small(int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   task automatic add_line(int s, int b);
      stim_q.push_back(make_req(OP_ADD, s, b, $urandom));
   endtask

   task automatic query_at(int x);
      stim_q.push_back(make_req(OP_QUERY, $urandom, $urandom, x));
   endtask

   // directed opening: empty table, extremes, equal slopes, saturation
   task automatic build_directed();
      query_at(0);
      query_at(32'h8000_0000);
      add_line(3, 3);
      add_line(3, 5);
      query_at(-7);
      add_line(3, 2);
      query_at(4);
      add_line(32'h8000_0000, 32'h8000_0000);
      add_line(32'h7fff_ffff, 32'h7fff_ffff);
      query_at(32'h7fff_ffff);
      query_at(32'h8000_0000);
      query_at(0);
      query_at(-1);
      add_line(0, 32'h7fff_ffff);
      query_at(1);
      query_at(-1);
      add_line(-1, -1);
      add_line(1, 32'h8000_0000);
      query_at(12345);
   endtask

   // random part: mostly small coefficients so lines tie and prune, some full range
   task automatic build_random(int n);
      int mode;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(9);
         if (mode < 4) begin
            add_line(rand_small(8), rand_small(60));
         end else if (mode < 5) begin
            add_line($urandom, $urandom);
         end else if (mode < 8) begin
            query_at(rand_small(30));
         end else if (mode < 9) begin
            query_at($urandom);
         end else begin
            query_at($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
         end
      end
   endtask

   // fill the table with lines that all stay on the envelope, then overrun it
   task automatic build_fill();
      for (int k = -34; k <= 40; k++) begin
         add_line(k * 7 + 5000, -k * k * 1000);
         if (k % 4 == 0) query_at(rand_small(200));
      end
      for (int i = 0; i < 20; i++) query_at($urandom_range(1) ? rand_small(50) : $urandom);
      add_line(32'h7fff_ffff, 32'h7fff_ffff);
   endtask

   // one rising edge: note accepted transaction, check response, then drive
   task automatic drive_step();
      if (start && !busy) begin
         sb.note_request(req_data);
         idle_cycles = 0;
      end
      if (rsp_valid) begin
         sb.check_response(rsp_data);
         idle_cycles = 0;
      end
      if (start && busy) begin
         // hold the current transaction
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (stim_q.size() > 0) begin
         req_data <= stim_q.pop_front();
         start <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(12);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
         end
      end else begin
         start <= 1'b0;
      end
   endtask

   // watchdog on cycles with no transaction either way
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      burst_left = 0;
      gap_left = 0;
      idle_cycles = 0;
      build_directed();
      build_random(1550);
      build_fill();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() > 0 || start || sb.pending_q.size() > 0) begin
         @(posedge clock);
         drive_step();
      end
      repeat (DrainWait) begin
         @(posedge clock);
         drive_step();
      end
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
